@@ sv/otp_controller_registers_top_macros.svh @@
// Assertion macros for the fuse controller register checker.
`ifndef OTP_CONTROLLER_REGISTERS_TOP_MACROS_SVH
`define OTP_CONTROLLER_REGISTERS_TOP_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define OTPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define OTPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/otpc_pkg.sv @@
// Types and constants for the fuse controller register block.
package otpc_pkg;

    localparam int CUSTOMER_COUNT = 4;
    localparam int KEY_COUNT      = 4;
    localparam int ROM_COUNT      = 3;

    localparam logic [15:0] KEY_VALUE     = 16'h3E77;
    localparam logic [31:0] BAD_WORD      = 32'hBADABADA;
    localparam logic [31:0] VERSION_RESET = 32'h01010000;
    localparam logic [2:0]  SIZE_WORD     = 3'd4;

    // Register offsets
    localparam logic [9:0] OFS_CTRL      = 10'h000;
    localparam logic [9:0] OFS_DATA      = 10'h010;
    localparam logic [9:0] OFS_SHADOW_CAP = 10'h110;
    localparam logic [9:0] OFS_SHADOW_LCK = 10'h120;
    localparam logic [9:0] OFS_VERSION   = 10'h220;
    localparam logic [9:0] OFS_CUST_BASE = 10'h020;
    localparam logic [9:0] OFS_CUST_END  = 10'h060;
    localparam logic [9:0] OFS_KEY_BASE  = 10'h060;
    localparam logic [9:0] OFS_KEY_END   = 10'h0A0;
    localparam logic [9:0] OFS_ROM_BASE  = 10'h1A0;
    localparam logic [9:0] OFS_ROM_END   = 10'h1D0;

    // Control register aliases
    localparam logic [3:0] CTRL_WRITE = 4'h0;
    localparam logic [3:0] CTRL_SET   = 4'h4;
    localparam logic [3:0] CTRL_CLR   = 4'h8;
    localparam logic [3:0] CTRL_TOG   = 4'hC;

    // Program address map
    localparam logic [4:0] PA_KEY_FIRST = 5'h04;
    localparam logic [4:0] PA_CAP       = 5'h0F;
    localparam logic [4:0] PA_LOCK      = 5'h10;
    localparam logic [4:0] PA_ROM_FIRST = 5'h18;

    // Shadow lock bits
    localparam int LOCK_KEY_BIT    = 4;
    localparam int LOCK_SHCAP_BIT  = 7;
    localparam int LOCK_CAP_BIT    = 9;

    localparam int FUNC_READ = 0;

    typedef struct packed {
        logic        func;
        logic [9:0]  offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } otpc_access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        error_flag;
    } otpc_result_t;

endpackage

@@ sv/otpc_core.sv @@
// Register state and access decode of the fuse controller.
module otpc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  commit,
    input  otpc_pkg::otpc_access_t access,
    input  logic [31:0]           version_word,
    output otpc_pkg::otpc_result_t result
);
    import otpc_pkg::*;

    logic [15:0] key_reg, key_next;
    logic        reload_reg, reload_next;
    logic        open_reg, open_next;
    logic        err_reg, err_next;
    logic [4:0]  addr_reg, addr_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] cust_reg [CUSTOMER_COUNT];
    logic [31:0] cust_next [CUSTOMER_COUNT];
    logic [31:0] keyw_reg [KEY_COUNT];
    logic [31:0] keyw_next [KEY_COUNT];
    logic [31:0] rom_reg [ROM_COUNT];
    logic [31:0] rom_next [ROM_COUNT];
    logic [31:0] fcap_reg, fcap_next;
    logic [31:0] scap_reg, scap_next;
    logic [31:0] flock_reg, flock_next;
    logic [31:0] slock_reg, slock_next;

    logic [9:0]  cust_rel, key_rel, rom_rel;
    logic [31:0] rd;

    assign cust_rel = access.offset - OFS_CUST_BASE;
    assign key_rel  = access.offset - OFS_KEY_BASE;
    assign rom_rel  = access.offset - OFS_ROM_BASE;

    always_comb begin
        logic [31:0] v;
        logic [15:0] vkey;
        logic        acted;
        v     = access.write_data;
        vkey  = v[31:16];
        acted = 1'b0;

        key_next    = key_reg;
        reload_next = reload_reg;
        open_next   = open_reg;
        err_next    = err_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        cust_next   = cust_reg;
        keyw_next   = keyw_reg;
        rom_next    = rom_reg;
        fcap_next   = fcap_reg;
        scap_next   = scap_reg;
        flock_next  = flock_reg;
        slock_next  = slock_reg;
        rd          = '0;

        if (access.access_size == SIZE_WORD) begin
            if (access.func == 1'(FUNC_READ)) begin
                priority if (access.offset == OFS_CTRL) begin
                    rd = {key_reg, 2'b00, reload_reg, open_reg, 2'b00, err_reg,
                          4'b0000, addr_reg};
                end else if (access.offset == OFS_DATA) begin
                    rd = data_reg;
                end else if (access.offset == OFS_SHADOW_CAP) begin
                    rd = scap_reg;
                end else if (access.offset == OFS_SHADOW_LCK) begin
                    rd = slock_reg;
                end else if (access.offset == OFS_VERSION) begin
                    rd = version_word;
                end else if (access.offset >= OFS_CUST_BASE && access.offset < OFS_CUST_END) begin
                    if (!open_reg) begin
                        err_next = 1'b1;
                        rd       = BAD_WORD;
                    end else begin
                        rd = cust_reg[cust_rel[5:4]];
                    end
                end else if (access.offset >= OFS_KEY_BASE && access.offset < OFS_KEY_END) begin
                    if (!open_reg || slock_reg[LOCK_KEY_BIT]) begin
                        err_next = 1'b1;
                        rd       = BAD_WORD;
                    end else begin
                        rd = keyw_reg[key_rel[5:4]];
                    end
                end else if (access.offset >= OFS_ROM_BASE && access.offset < OFS_ROM_END) begin
                    if (!open_reg) begin
                        err_next = 1'b1;
                        rd       = BAD_WORD;
                    end else begin
                        rd = rom_reg[rom_rel[5:4]];
                    end
                end else begin
                    rd = '0;
                end
            end else begin
                priority if (access.offset[9:4] == OFS_CTRL[9:4]) begin
                    acted = 1'b1;
                    unique case (access.offset[3:0])
                        CTRL_WRITE: begin
                            key_next    = (vkey == KEY_VALUE) ? KEY_VALUE : 16'h0000;
                            reload_next = v[13];
                            open_next   = v[12];
                            addr_next   = v[4:0];
                        end
                        CTRL_SET: begin
                            if (vkey == KEY_VALUE) key_next = key_reg | KEY_VALUE;
                            reload_next = reload_reg | v[13];
                            open_next   = open_reg | v[12];
                            addr_next   = addr_reg | v[4:0];
                        end
                        CTRL_CLR: begin
                            key_next    = key_reg & ~vkey;
                            reload_next = reload_reg & ~v[13];
                            open_next   = open_reg & ~v[12];
                            addr_next   = addr_reg & ~v[4:0];
                            if (v[9]) err_next = 1'b0;
                        end
                        CTRL_TOG: begin
                            reload_next = reload_reg ^ v[13];
                            open_next   = open_reg ^ v[12];
                            addr_next   = addr_reg ^ v[4:0];
                        end
                        default: acted = 1'b0;
                    endcase
                    // reload completes once the banks are closed
                    if (acted && reload_next && !open_next) begin
                        scap_next   = fcap_reg;
                        slock_next  = flock_reg;
                        reload_next = 1'b0;
                    end
                end else if (access.offset == OFS_DATA) begin
                    data_next = v;
                    if (!err_reg && key_reg == KEY_VALUE) begin
                        priority if (addr_reg < PA_KEY_FIRST) begin
                            if (slock_reg[addr_reg[1:0]]) err_next = 1'b1;
                            else cust_next[addr_reg[1:0]] = cust_reg[addr_reg[1:0]] | v;
                        end else if (addr_reg < PA_KEY_FIRST + 5'(KEY_COUNT)) begin
                            if (slock_reg[LOCK_KEY_BIT]) err_next = 1'b1;
                            else keyw_next[addr_reg[1:0]] = keyw_reg[addr_reg[1:0]] | v;
                        end else if (addr_reg == PA_CAP) begin
                            if (slock_reg[LOCK_CAP_BIT]) err_next = 1'b1;
                            else fcap_next = fcap_reg | v;
                        end else if (addr_reg == PA_LOCK) begin
                            flock_next = flock_reg | v;
                        end else if (addr_reg >= PA_ROM_FIRST
                                     && addr_reg < PA_ROM_FIRST + 5'(ROM_COUNT)) begin
                            rom_next[addr_reg[1:0]] = rom_reg[addr_reg[1:0]] | v;
                        end else begin
                            err_next = 1'b1;
                        end
                        if (!err_next) key_next = '0;
                    end
                end else if (access.offset == OFS_SHADOW_CAP) begin
                    if (slock_reg[LOCK_SHCAP_BIT]) err_next = 1'b1;
                    else scap_next = v;
                end else begin
                    acted = 1'b0;
                end
            end
        end
    end

    assign result.read_data  = rd;
    assign result.error_flag = err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= '0;
            reload_reg <= 1'b0;
            open_reg   <= 1'b0;
            err_reg    <= 1'b0;
            addr_reg   <= '0;
            data_reg   <= '0;
            for (int i = 0; i < CUSTOMER_COUNT; i++) cust_reg[i] <= '0;
            for (int i = 0; i < KEY_COUNT; i++) keyw_reg[i] <= '0;
            for (int i = 0; i < ROM_COUNT; i++) rom_reg[i] <= '0;
            fcap_reg   <= '0;
            scap_reg   <= '0;
            flock_reg  <= '0;
            slock_reg  <= '0;
        end else if (commit) begin
            key_reg    <= key_next;
            reload_reg <= reload_next;
            open_reg   <= open_next;
            err_reg    <= err_next;
            addr_reg   <= addr_next;
            data_reg   <= data_next;
            cust_reg   <= cust_next;
            keyw_reg   <= keyw_next;
            rom_reg    <= rom_next;
            fcap_reg   <= fcap_next;
            scap_reg   <= scap_next;
            flock_reg  <= flock_next;
            slock_reg  <= slock_next;
        end
    end

endmodule

@@ sv/otp_controller_registers_top.sv @@
// Top level of the fuse controller register block: stream ports and pipeline control.
// The access is registered in the input stage, then its result in the output register,
// which raises m_tvalid once that register is free or m_tready takes its old result.
// Throughput: one access per cycle unless the output stalls; state update and result are
// computed in one pass. An empty input stage also takes a transfer while a result waits.
// Reset (aresetn low, synchronous) clears both stages, all fuse, shadow and control state,
// and returns the version word to 0x01010000.
module otp_controller_registers_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // version_word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // offset[9:0], access_size[12:10], write_data[44:13]
    input  logic        s_tuser,       // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // read_data[31:0], error_flag[32]
);
    import otpc_pkg::*;

    logic         in_valid_reg, in_valid_next;
    otpc_access_t acc_reg;
    logic         out_valid_reg, out_valid_next;
    otpc_result_t out_reg;
    otpc_result_t res;
    logic [31:0]  version_reg;
    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            version_reg   <= VERSION_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) version_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            acc_reg.func        <= s_tuser;
            acc_reg.offset      <= s_tdata[9:0];
            acc_reg.access_size <= s_tdata[12:10];
            acc_reg.write_data  <= s_tdata[44:13];
        end
        if (advance) out_reg <= res;
    end

    otpc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .commit       (advance),
        .access       (acc_reg),
        .version_word (version_reg),
        .result       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.error_flag, out_reg.read_data};

endmodule

@@ sv/otpc_checker.sv @@
// Port-level checks for the fuse controller register block, bound to the top level.
`include "otp_controller_registers_top_macros.svh"

module otpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // input only backs up when a finished result is stuck at the output
    `OTPC_ASSERT(a_stall_only_on_full, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
    `OTPC_ASSERT_ALWAYS(a_reset_clears_out, $past(!aresetn) |-> !m_tvalid, "result valid right after reset")
    `OTPC_ASSERT(a_valid_holds, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
    `OTPC_ASSERT(a_data_holds, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")

endmodule

bind otp_controller_registers_top otpc_checker u_otpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb.sv @@
// Stream-level testbench for the fuse controller registers: random bus accesses checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import otpc_pkg::*;

    localparam logic FN_RD = 1'b0;
    localparam logic FN_WR = 1'b1;
    localparam int CTL_RELOAD = 13;
    localparam int CTL_OPEN   = 12;
    localparam int CTL_ERR    = 9;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;

    otp_controller_registers_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Predicted register and fuse state
    logic [15:0] ctl_key;
    logic        ctl_reload, ctl_open, ctl_err;
    logic [4:0]  ctl_addr;
    logic [31:0] data_reg;
    logic [31:0] cust_fuse   [CUSTOMER_COUNT];
    logic [31:0] crypto_fuse [KEY_COUNT];
    logic [31:0] rom_fuse    [ROM_COUNT];
    logic [31:0] cap_fuse, cap_shadow, lock_fuse, lock_shadow;
    logic [31:0] version_reg;

    otpc_access_t pending_acc [$];
    otpc_result_t due_results [$];
    int n_queued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;

    logic         in_taken = 1'b0;
    otpc_access_t tx_item, rx_item;
    otpc_result_t rx_res, want;
    int burst_left = 0;
    int gap_left   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic logic [9:0] ctrl_ofs(logic [3:0] al);
        return OFS_CTRL | {6'd0, al};
    endfunction

    task automatic fuse_regs_access(input otpc_access_t a, output otpc_result_t r);
        logic [31:0] rd;
        logic [31:0] wd;
        logic [15:0] vkey;
        logic        acted;
        logic [9:0]  rel;
        rd    = '0;
        wd    = a.write_data;
        vkey  = wd[31:16];
        acted = 1'b1;
        rel   = '0;
        if (a.access_size == SIZE_WORD) begin
            if (a.func == FN_RD) begin
                case (a.offset)
                    OFS_CTRL: rd = {ctl_key, 2'b0, ctl_reload, ctl_open, 2'b0, ctl_err, 4'b0,
                                    ctl_addr};
                    OFS_DATA:       rd = data_reg;
                    OFS_SHADOW_CAP: rd = cap_shadow;
                    OFS_SHADOW_LCK: rd = lock_shadow;
                    OFS_VERSION:    rd = version_reg;
                    default: begin
                        if (a.offset >= OFS_CUST_BASE && a.offset < OFS_CUST_END) begin
                            if (!ctl_open) begin
                                ctl_err = 1'b1;
                                rd = BAD_WORD;
                            end else begin
                                rel = a.offset - OFS_CUST_BASE;
                                rd = cust_fuse[rel[5:4]];
                            end
                        end else if (a.offset >= OFS_KEY_BASE && a.offset < OFS_KEY_END) begin
                            if (!ctl_open || lock_shadow[LOCK_KEY_BIT]) begin
                                ctl_err = 1'b1;
                                rd = BAD_WORD;
                            end else begin
                                rel = a.offset - OFS_KEY_BASE;
                                rd = crypto_fuse[rel[5:4]];
                            end
                        end else if (a.offset >= OFS_ROM_BASE && a.offset < OFS_ROM_END) begin
                            if (!ctl_open) begin
                                ctl_err = 1'b1;
                                rd = BAD_WORD;
                            end else begin
                                rel = a.offset - OFS_ROM_BASE;
                                rd = rom_fuse[rel[5:4]];
                            end
                        end
                    end
                endcase
            end else if (a.offset[9:4] == OFS_CTRL[9:4]) begin
                case (a.offset[3:0])
                    CTRL_WRITE: begin
                        ctl_key    = (vkey == KEY_VALUE) ? KEY_VALUE : 16'h0;
                        ctl_reload = wd[CTL_RELOAD];
                        ctl_open   = wd[CTL_OPEN];
                        ctl_addr   = wd[4:0];
                    end
                    CTRL_SET: begin
                        if (vkey == KEY_VALUE) ctl_key |= KEY_VALUE;
                        ctl_reload |= wd[CTL_RELOAD];
                        ctl_open   |= wd[CTL_OPEN];
                        ctl_addr   |= wd[4:0];
                    end
                    CTRL_CLR: begin
                        ctl_key    &= ~vkey;
                        ctl_reload &= ~wd[CTL_RELOAD];
                        ctl_open   &= ~wd[CTL_OPEN];
                        ctl_addr   &= ~wd[4:0];
                        if (wd[CTL_ERR]) ctl_err = 1'b0;
                    end
                    CTRL_TOG: begin
                        ctl_reload ^= wd[CTL_RELOAD];
                        ctl_open   ^= wd[CTL_OPEN];
                        ctl_addr   ^= wd[4:0];
                    end
                    default: acted = 1'b0;
                endcase
                // shadows reload once the banks are closed
                if (acted && ctl_reload && !ctl_open) begin
                    cap_shadow  = cap_fuse;
                    lock_shadow = lock_fuse;
                    ctl_reload  = 1'b0;
                end
            end else if (a.offset == OFS_DATA) begin
                data_reg = wd;
                if (!ctl_err && ctl_key == KEY_VALUE) begin
                    if (ctl_addr < PA_KEY_FIRST) begin
                        if (lock_shadow[ctl_addr]) ctl_err = 1'b1;
                        else cust_fuse[ctl_addr[1:0]] |= wd;
                    end else if (ctl_addr < PA_KEY_FIRST + 5'(KEY_COUNT)) begin
                        if (lock_shadow[LOCK_KEY_BIT]) ctl_err = 1'b1;
                        else crypto_fuse[ctl_addr[1:0]] |= wd;
                    end else if (ctl_addr == PA_CAP) begin
                        if (lock_shadow[LOCK_CAP_BIT]) ctl_err = 1'b1;
                        else cap_fuse |= wd;
                    end else if (ctl_addr == PA_LOCK) begin
                        lock_fuse |= wd;
                    end else if (ctl_addr >= PA_ROM_FIRST
                                 && ctl_addr < PA_ROM_FIRST + 5'(ROM_COUNT)) begin
                        rom_fuse[ctl_addr[1:0]] |= wd;
                    end else begin
                        ctl_err = 1'b1;
                    end
                    if (!ctl_err) ctl_key = 16'h0;
                end
            end else if (a.offset == OFS_SHADOW_CAP) begin
                if (lock_shadow[LOCK_SHCAP_BIT]) ctl_err = 1'b1;
                else cap_shadow = wd;
            end
        end
        r.read_data  = rd;
        r.error_flag = ctl_err;
    endtask

    task automatic push_acc(logic fn, logic [9:0] ofs, logic [2:0] sz, logic [31:0] wd);
        otpc_access_t a;
        a.func        = fn;
        a.offset      = ofs;
        a.access_size = sz;
        a.write_data  = wd;
        pending_acc.push_back(a);
        n_queued++;
    endtask

    // One random access or a short well-formed sequence of accesses
    task automatic queue_random_seq();
        int          pick, n, b;
        logic [4:0]  pa;
        logic [31:0] rnd, wd;
        logic [15:0] kv;
        logic [9:0]  ofs;
        pick = $urandom_range(0, 99);
        rnd  = $urandom;
        if (pick < 15) begin
            push_acc(rnd[0], 10'($urandom_range(0, 767)), 3'($urandom_range(1, 4)), $urandom);
        end else if (pick < 40) begin
            // unlock, address, program
            if ($urandom_range(0, 4) < 3)
                push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_ERR);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pa = 5'($urandom_range(0, 3));
                4, 5:       pa = PA_KEY_FIRST + 5'($urandom_range(0, 3));
                6:          pa = PA_CAP;
                7, 8:       pa = PA_ROM_FIRST + 5'($urandom_range(0, 2));
                default:    pa = rnd[4:0];
            endcase
            if ($urandom_range(0, 49) == 0) pa = PA_LOCK;
            kv = ($urandom_range(0, 9) == 0) ? rnd[31:16] : KEY_VALUE;
            wd = {kv, 3'b000, rnd[12], rnd[11:5], pa};
            push_acc(FN_WR, ctrl_ofs(($urandom_range(0, 4) == 0) ? CTRL_SET : CTRL_WRITE),
                     SIZE_WORD, wd);
            if (pa == PA_LOCK) wd = 32'h1 << $urandom_range(0, 31);
            else if ($urandom_range(0, 4) == 0) wd = $urandom;
            else wd = $urandom & $urandom & $urandom;
            push_acc(FN_WR, OFS_DATA, SIZE_WORD, wd);
        end else if (pick < 60) begin
            // open or close the banks, then read them
            if ($urandom_range(0, 3) != 0)
                push_acc(FN_WR, ctrl_ofs(CTRL_SET), SIZE_WORD, 32'h1 << CTL_OPEN);
            else
                push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_OPEN);
            n = $urandom_range(1, 4);
            repeat (n) begin
                b = $urandom_range(0, 2);
                if (b == 0)
                    ofs = OFS_CUST_BASE + 10'($urandom_range(0, 16 * CUSTOMER_COUNT - 1));
                else if (b == 1)
                    ofs = OFS_KEY_BASE + 10'($urandom_range(0, 16 * KEY_COUNT - 1));
                else
                    ofs = OFS_ROM_BASE + 10'($urandom_range(0, 16 * ROM_COUNT - 1));
                push_acc(FN_RD, ofs, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 3))
                                                               : SIZE_WORD, $urandom);
            end
        end else if (pick < 70) begin
            // reload of the shadows
            if (rnd[0]) begin
                push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD,
                         {16'h0, 2'b00, 1'b1, 1'b0, rnd[11:0]});
            end else begin
                push_acc(FN_WR, ctrl_ofs(CTRL_SET), SIZE_WORD,
                         (32'h1 << CTL_RELOAD) | (32'h1 << CTL_OPEN));
                push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_OPEN);
            end
            push_acc(FN_RD, OFS_SHADOW_LCK, SIZE_WORD, $urandom);
        end else if (pick < 80) begin
            wd = rnd[1] ? (32'h1 << CTL_ERR) : ($urandom | (32'h1 << CTL_ERR));
            push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, wd);
            push_acc(FN_RD, OFS_CTRL, SIZE_WORD, $urandom);
        end else if (pick < 88) begin
            case ($urandom_range(0, 4))
                0:       ofs = OFS_CTRL;
                1:       ofs = OFS_DATA;
                2:       ofs = OFS_SHADOW_CAP;
                3:       ofs = OFS_SHADOW_LCK;
                default: ofs = OFS_VERSION;
            endcase
            push_acc(FN_RD, ofs, SIZE_WORD, $urandom);
        end else if (pick < 94) begin
            push_acc(FN_WR, OFS_SHADOW_CAP, SIZE_WORD, $urandom);
            push_acc(FN_RD, OFS_SHADOW_CAP, SIZE_WORD, $urandom);
        end else begin
            wd = $urandom;
            if (rnd[2]) wd[31:16] = KEY_VALUE;
            push_acc(FN_WR, ctrl_ofs(rnd[7:4]), SIZE_WORD, wd);
        end
    endtask

    task automatic set_version(logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        version_reg = v;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || due_results.size() != 0) @(negedge aclk);
        // latency tail of the two-stage pipe
        repeat (4) @(negedge aclk);
    endtask

    // Sender: bursts of transfers with random gaps between them
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (gap_left > 0 || pending_acc.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                tx_item = pending_acc.pop_front();
                s_tdata  <= {3'b000, tx_item.write_data, tx_item.access_size, tx_item.offset};
                s_tuser  <= tx_item.func;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: backpressure pattern that changes mode now and then
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 60);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (rx_left[1:0] == 2'b00);
            default: m_tready <= (rx_left < 4);
        endcase
    end

    // Check results, then predict for the input transfer of this edge
    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[31:0] !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h", $time,
                                 want.read_data, m_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_tdata[32] !== want.error_flag) begin
                        $display("%0t: error_flag expected %b actual %b", $time,
                                 want.error_flag, m_tdata[32]);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                rx_item.func        = s_tuser;
                rx_item.offset      = s_tdata[9:0];
                rx_item.access_size = s_tdata[12:10];
                rx_item.write_data  = s_tdata[44:13];
                fuse_regs_access(rx_item, rx_res);
                due_results.push_back(rx_res);
                n_accepted++;
                in_taken = 1'b1;
            end
        end
    end

    initial begin
        int target;
        logic [31:0] ver_set [4];
        ctl_key = '0;
        ctl_reload = 1'b0;
        ctl_open = 1'b0;
        ctl_err = 1'b0;
        ctl_addr = '0;
        data_reg = '0;
        foreach (cust_fuse[i]) cust_fuse[i] = '0;
        foreach (crypto_fuse[i]) crypto_fuse[i] = '0;
        foreach (rom_fuse[i]) rom_fuse[i] = '0;
        cap_fuse = '0;
        cap_shadow = '0;
        lock_fuse = '0;
        lock_shadow = '0;
        version_reg = VERSION_RESET;
        ver_set[0] = 32'h0;
        ver_set[1] = 32'hFFFF_FFFF;
        ver_set[2] = $urandom;
        ver_set[3] = VERSION_RESET;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset values, ignored sizes and aliases, program, reload, edges
        push_acc(FN_RD, OFS_VERSION, SIZE_WORD, '0);
        push_acc(FN_RD, OFS_CTRL, SIZE_WORD, '0);
        push_acc(FN_RD, OFS_CUST_BASE + 10'h4, SIZE_WORD, '0);        // closed bank
        push_acc(FN_RD, OFS_CTRL, 3'd2, '0);                           // not word sized
        push_acc(FN_WR, OFS_CTRL, 3'd1, 32'hFFFF_FFFF);
        push_acc(FN_WR, ctrl_ofs(4'h3), SIZE_WORD, 32'hFFFF_FFFF);     // dead alias
        push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_ERR);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, {KEY_VALUE, 16'h1000});
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'hFFFF_FFFF);
        push_acc(FN_RD, OFS_CUST_BASE + 10'hF, SIZE_WORD, '0);
        push_acc(FN_RD, OFS_DATA, SIZE_WORD, '0);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, {KEY_VALUE, 16'h101B}); // bad address
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'h1);
        push_acc(FN_RD, OFS_CTRL, SIZE_WORD, '0);
        push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'hFFFF_021F);
        push_acc(FN_WR, ctrl_ofs(CTRL_SET), SIZE_WORD, {KEY_VALUE, 16'h101A});
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'hA5A5_0000);
        push_acc(FN_RD, OFS_ROM_BASE + 10'h20, SIZE_WORD, '0);
        push_acc(FN_WR, ctrl_ofs(CTRL_TOG), SIZE_WORD, 32'h0000_301F); // reload on, banks close
        push_acc(FN_RD, OFS_SHADOW_LCK, SIZE_WORD, '0);
        push_acc(FN_WR, OFS_SHADOW_CAP, SIZE_WORD, 32'h1234_5678);
        push_acc(FN_RD, OFS_SHADOW_CAP, SIZE_WORD, '0);
        push_acc(FN_RD, 10'h2FF, SIZE_WORD, '0);
        push_acc(FN_WR, 10'h2FF, SIZE_WORD, 32'hFFFF_FFFF);
        push_acc(FN_RD, OFS_KEY_BASE, SIZE_WORD, '0);
        wait_idle();

        foreach (ver_set[p]) begin
            set_version(ver_set[p]);
            target = n_queued + 140;
            while (n_queued < target) queue_random_seq();
            wait_idle();
        end

        // directed: locked words
        push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_ERR);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, {KEY_VALUE, 11'h0, PA_LOCK});
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'h0000_0294);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, 32'h1 << CTL_RELOAD);
        push_acc(FN_WR, ctrl_ofs(CTRL_SET), SIZE_WORD, 32'h1 << CTL_OPEN);
        push_acc(FN_RD, OFS_KEY_BASE + 10'h10, SIZE_WORD, '0);
        push_acc(FN_RD, OFS_SHADOW_LCK, SIZE_WORD, '0);
        push_acc(FN_WR, OFS_SHADOW_CAP, SIZE_WORD, 32'hFFFF_FFFF);
        push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_ERR);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, {KEY_VALUE, 11'h080, PA_CAP});
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'h1);
        push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_ERR);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, {KEY_VALUE, 16'h1002});
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'h1);
        push_acc(FN_WR, ctrl_ofs(CTRL_CLR), SIZE_WORD, 32'h1 << CTL_ERR);
        push_acc(FN_WR, ctrl_ofs(CTRL_WRITE), SIZE_WORD, {KEY_VALUE, 16'h1005});
        push_acc(FN_WR, OFS_DATA, SIZE_WORD, 32'h1);
        push_acc(FN_RD, OFS_CTRL, SIZE_WORD, '0);
        wait_idle();

        repeat (8) @(negedge aclk);
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

@@ otp_controller_registers_top.f @@
+incdir+sv
sv/otpc_pkg.sv
sv/otpc_core.sv
sv/otp_controller_registers_top.sv
sv/otpc_checker.sv
tb/sv/tb.sv
